// ===== hw/rtl/dfd_pkg.sv =====
package dfd_pkg;

  localparam int unsigned OUT_IDX_W = 6;

  localparam logic [15:0] HEADER_RESET = 16'hAA55;
  localparam logic [15:0] TAIL_RESET   = 16'hACBC;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_HEADER = 3'd1;
  localparam logic [2:0] ST_BAD_LEN   = 3'd2;
  localparam logic [2:0] ST_BAD_SUM   = 3'd3;
  localparam logic [2:0] ST_BAD_TAIL  = 3'd4;
  localparam logic [2:0] ST_TRUNC     = 3'd5;

  localparam logic REG_HEADER = 1'b0;
  localparam logic REG_TAIL   = 1'b1;

  typedef struct packed {
    logic take;
    logic rd_clear;
    logic rd_issue;
    logic send_word;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic res_ok;
    logic rd_last;
  } stat_t;

endpackage

// ===== hw/rtl/dfd_in_if.sv =====
interface dfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       window_end;

  modport source (output valid, output rx_byte, output window_end, input ready);
  modport sink (input valid, input rx_byte, input window_end, output ready);
endinterface

// ===== hw/rtl/dfd_out_if.sv =====
interface dfd_out_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     status;
  logic [dfd_pkg::OUT_IDX_W-1:0]  word_index;
  logic [15:0]                    word_value;
  logic                           last;

  modport source (output valid, output status, output word_index, output word_value,
                  output last, input ready);
  modport sink (input valid, input status, input word_index, input word_value,
                input last, output ready);
endinterface

// ===== hw/rtl/dfd_ctrl.sv =====
module dfd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  dfd_pkg::stat_t stat,
  output dfd_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEND
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    in_ready       = (state == S_IDLE) && stat.out_free;
    cmd            = '0;
    cmd.take       = in_valid && in_ready;
    cmd.rd_clear   = cmd.take && stat.res_ok;
    cmd.rd_issue   = (state == S_READ);
    cmd.send_word  = (state == S_SEND) && stat.out_free;
    state_next     = state;
    case (state)
      S_IDLE: begin
        if (cmd.take && stat.res_ok) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_SEND;
      end
      S_SEND: begin
        if (stat.out_free) state_next = stat.rd_last ? S_IDLE : S_READ;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/dfd_dp.sv =====
module dfd_dp #(
  parameter int unsigned CONTENT_WORDS = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dfd_pkg::cmd_t                 cmd,
  output dfd_pkg::stat_t                stat,
  input  logic [15:0]                   header_word,
  input  logic [15:0]                   tail_word,
  input  logic [7:0]                    rx_byte,
  input  logic                          window_end,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [2:0]                    out_status,
  output logic [dfd_pkg::OUT_IDX_W-1:0] out_index,
  output logic [15:0]                   out_value,
  output logic                          out_last
);

  localparam int unsigned FRAME_BYTES = 2 * CONTENT_WORDS + 8;
  localparam int unsigned CNT_W = $clog2(FRAME_BYTES + 1);
  localparam int unsigned K_W = CNT_W - 1;
  localparam int unsigned IDX_W = (CONTENT_WORDS > 1) ? $clog2(CONTENT_WORDS) : 1;
  localparam logic [15:0] LEN_EXPECTED = 16'(2 * CONTENT_WORDS);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_COLLECT,
    PH_DONE
  } phase_t;

  phase_t           phase;
  phase_t           phase_next;
  logic [7:0]       prev_byte;
  logic [7:0]       prev_byte_next;
  logic [CNT_W-1:0] byte_count;
  logic [CNT_W-1:0] byte_count_next;
  logic [7:0]       low_byte_hold;
  logic [7:0]       low_byte_hold_next;
  logic [15:0]      running_sum;
  logic [15:0]      running_sum_next;
  logic             length_ok;
  logic             length_ok_next;
  logic [15:0]      received_sum;
  logic [15:0]      received_sum_next;

  logic [15:0]      word_store [CONTENT_WORDS];
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;
  logic [15:0]      rd_data;

  logic [15:0]      word;
  logic [K_W-1:0]   k;
  logic             st_en;
  logic [2:0]       st_code;
  logic             res_ok;

  always_comb begin
    phase_next         = phase;
    prev_byte_next     = prev_byte;
    byte_count_next    = byte_count;
    low_byte_hold_next = low_byte_hold;
    running_sum_next   = running_sum;
    length_ok_next     = length_ok;
    received_sum_next  = received_sum;
    wr_en              = 1'b0;
    word               = {rx_byte, low_byte_hold};
    k                  = byte_count[CNT_W-1:1];
    wr_idx             = IDX_W'(k - K_W'(2));
    st_en              = 1'b0;
    st_code            = dfd_pkg::ST_OK;
    res_ok             = 1'b0;
    if (cmd.take) begin
      case (phase)
        PH_HUNT: begin
          if (byte_count != '0 && prev_byte == header_word[7:0] &&
              rx_byte == header_word[15:8]) begin
            phase_next        = PH_COLLECT;
            byte_count_next   = CNT_W'(2);
            running_sum_next  = header_word;
            length_ok_next    = 1'b0;
            received_sum_next = '0;
          end else begin
            prev_byte_next  = rx_byte;
            byte_count_next = CNT_W'(1);
          end
        end
        PH_COLLECT: begin
          if (!byte_count[0]) begin
            low_byte_hold_next = rx_byte;
          end else if (k == K_W'(1)) begin
            length_ok_next   = (word == LEN_EXPECTED);
            running_sum_next = running_sum + word;
          end else if (k >= K_W'(2) && k < K_W'(2 + CONTENT_WORDS)) begin
            wr_en            = 1'b1;
            running_sum_next = running_sum + word;
          end else if (k == K_W'(2 + CONTENT_WORDS)) begin
            received_sum_next = word;
          end else begin
            phase_next = PH_DONE;
            if (!length_ok) begin
              st_en   = 1'b1;
              st_code = dfd_pkg::ST_BAD_LEN;
            end else if (running_sum != received_sum) begin
              st_en   = 1'b1;
              st_code = dfd_pkg::ST_BAD_SUM;
            end else if (word != tail_word) begin
              st_en   = 1'b1;
              st_code = dfd_pkg::ST_BAD_TAIL;
            end else begin
              res_ok = 1'b1;
            end
          end
          if (phase_next == PH_COLLECT) byte_count_next = byte_count + CNT_W'(1);
        end
        default: ;
      endcase
      if (window_end) begin
        if (!st_en && !res_ok) begin
          if (phase_next == PH_HUNT) begin
            st_en   = 1'b1;
            st_code = dfd_pkg::ST_NO_HEADER;
          end else if (phase_next == PH_COLLECT) begin
            st_en   = 1'b1;
            st_code = dfd_pkg::ST_TRUNC;
          end
        end
        phase_next      = PH_HUNT;
        prev_byte_next  = '0;
        byte_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      prev_byte     <= '0;
      byte_count    <= '0;
      low_byte_hold <= '0;
      running_sum   <= '0;
      length_ok     <= 1'b0;
      received_sum  <= '0;
    end else begin
      phase         <= phase_next;
      prev_byte     <= prev_byte_next;
      byte_count    <= byte_count_next;
      low_byte_hold <= low_byte_hold_next;
      running_sum   <= running_sum_next;
      length_ok     <= length_ok_next;
      received_sum  <= received_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && wr_en) word_store[wr_idx] <= word;
    if (cmd.rd_issue) rd_data <= word_store[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
    end else if (cmd.rd_clear) begin
      rd_idx <= '0;
    end else if (cmd.send_word) begin
      rd_idx <= rd_idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.take && st_en) begin
      out_valid <= 1'b1;
    end else if (cmd.send_word) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && st_en) begin
      out_status <= st_code;
      out_index  <= '0;
      out_value  <= '0;
      out_last   <= 1'b1;
    end else if (cmd.send_word) begin
      out_status <= dfd_pkg::ST_OK;
      out_index  <= dfd_pkg::OUT_IDX_W'(rd_idx);
      out_value  <= rd_data;
      out_last   <= stat.rd_last;
    end
  end

  assign stat.out_free = !out_valid || out_ready;
  assign stat.res_ok   = res_ok;
  assign stat.rd_last  = (rd_idx == IDX_W'(CONTENT_WORDS - 1));

endmodule

// ===== hw/rtl/download_frame_deframer_unit.sv =====
// A status word is registered and appears in the cycle after the byte that decides it.
// A good frame streams its content words after the completing byte, each word
// through a memory read, then an output load that waits while the output is held.
// Throughput: one byte per cycle while the output is free; input stalls while a good frame's words are sent.
// Reset (rst, synchronous): hunting, counters and sums cleared, header/tail registers to defaults;
// word store contents are undefined until written.
module download_frame_deframer_unit #(
  parameter int unsigned CONTENT_WORDS = 48
) (
  input  logic        clk,
  input  logic        rst,
  dfd_in_if.sink      din,
  dfd_out_if.source   dout,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]    header_word;
  logic [15:0]    tail_word;
  dfd_pkg::cmd_t  cmd;
  dfd_pkg::stat_t stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_word <= dfd_pkg::HEADER_RESET;
      tail_word   <= dfd_pkg::TAIL_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        dfd_pkg::REG_HEADER: header_word <= pwdata[15:0];
        dfd_pkg::REG_TAIL:   tail_word   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      dfd_pkg::REG_HEADER: prdata = {16'h0000, header_word};
      dfd_pkg::REG_TAIL:   prdata = {16'h0000, tail_word};
      default:             prdata = '0;
    endcase
  end

  dfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_ready (din.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dfd_dp #(
    .CONTENT_WORDS (CONTENT_WORDS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .header_word (header_word),
    .tail_word   (tail_word),
    .rx_byte     (din.rx_byte),
    .window_end  (din.window_end),
    .out_ready   (dout.ready),
    .out_valid   (dout.valid),
    .out_status  (dout.status),
    .out_index   (dout.word_index),
    .out_value   (dout.word_value),
    .out_last    (dout.last)
  );

endmodule
